// File: rtl/core/signed_sum_ways_counter_core_defines.svh
// Assertion macros shared by the signed sum ways counter RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef SIGNED_SUM_WAYS_COUNTER_CORE_DEFINES_SVH
`define SIGNED_SUM_WAYS_COUNTER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SSWC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SSWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/sswc_pkg.sv
// Package for the signed sum ways counter: sizes, state codes and the
// saturating count helpers. No dependencies.
`default_nettype none

package sswc_pkg;

  localparam int MAX_SUM    = 1023;
  localparam int MAX_VALUE  = 255;
  localparam int COUNT_BITS = 32;

  localparam int TABLE_SIZE = 2 * MAX_SUM + 1;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int TOTAL_W    = $clog2(MAX_SUM + 1);
  localparam int RAM_AW     = IDX_W + 1;
  localparam int RAM_DEPTH  = 2 ** RAM_AW;

  localparam int VALUE_W  = 8;
  localparam int TARGET_W = 12;
  localparam int WAYS_W   = 32;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SWEEP  = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_FINISH = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [WAYS_W-1:0] ways_sat(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w[63:WAYS_W] != '0) ? '1 : w[WAYS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sswc_ram.sv
// Generic RAM: one write port, two read ports with
// registered read data. No dependencies.
`default_nettype none

module sswc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: rtl/core/signed_sum_ways_counter_core.sv
// Top level of the signed sum ways counter: sequencer, shared saturating
// adder and result register. Uses sswc_pkg, sswc_ram and the defines header.
//
//   Channel  Direction  Carries
//   s_*      in         tdata: value, target; tuser: first; tlast: last
//   m_*      out        tdata: ways; tuser: sum_too_large
//
// A value that fits sweeps the table through one saturating adder, one entry
// per cycle, set by the single RAM write port.
// An overflowing item skips the sweep and goes from ST_IDLE to ST_FINISH; a last item then passes ST_RESULT.
// Reset clears control state only; the count RAM is never cleared, since a
// first item sweeps from an implied single count at total zero.
// One result waiting on m_tready does not stop s_*; a second one holds the block.
`default_nettype none

`include "signed_sum_ways_counter_core_defines.svh"

module signed_sum_ways_counter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [7:0] value, [19:8] target, [23:20] zero
  input  wire logic        s_tuser,   // [0] first
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] ways
  output logic             m_tuser    // [0] sum_too_large
);

  sswc_pkg::state_t state, state_next;

  logic [sswc_pkg::TOTAL_W-1:0] running_total;
  logic                         bank_select;
  logic                         overflow_seen;
  logic                         delta_src;
  logic                         item_last;
  logic                         t_ok;
  logic [sswc_pkg::IDX_W-1:0]   t_idx;
  logic [sswc_pkg::IDX_W-1:0]   sweep_val;
  logic [sswc_pkg::IDX_W-1:0]   idx;

  logic                         p_valid;
  logic [sswc_pkg::IDX_W-1:0]   p_idx;
  logic                         p_lo;
  logic                         p_hi;
  logic                         p_lo_one;
  logic                         p_hi_one;

  logic [sswc_pkg::VALUE_W-1:0]         value;
  logic signed [sswc_pkg::TARGET_W-1:0] target;
  logic                                 s_fire;
  logic                                 out_free;
  logic [sswc_pkg::TOTAL_W-1:0]         total_base;
  logic                                 ovf_base;
  logic                                 fits;
  logic                                 start_sweep;

  logic [sswc_pkg::IDX_W-1:0] lo_idx;
  logic [sswc_pkg::IDX_W:0]   hi_sum;
  logic                       lo_ok;
  logic                       hi_ok;
  logic                       lo_one;
  logic                       hi_one;

  logic                        ram_we;
  logic [sswc_pkg::RAM_AW-1:0] ram_waddr;
  sswc_pkg::count_t            ram_wdata;
  logic [sswc_pkg::RAM_AW-1:0] ram_raddr_a;
  logic [sswc_pkg::RAM_AW-1:0] ram_raddr_b;
  sswc_pkg::count_t            ram_rdata_a;
  sswc_pkg::count_t            ram_rdata_b;
  sswc_pkg::count_t            lo_term;
  sswc_pkg::count_t            hi_term;

  assign value    = s_tdata[7:0];
  assign target   = s_tdata[19:8];
  assign s_tready = (state == sswc_pkg::ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // A first item restarts the list before its own value is applied.
  assign total_base  = s_tuser ? '0 : running_total;
  assign ovf_base    = s_tuser ? 1'b0 : overflow_seen;
  assign fits        = (int'(value) <= sswc_pkg::MAX_VALUE) &&
                       (int'(total_base) + int'(value) <= sswc_pkg::MAX_SUM);
  assign start_sweep = !ovf_base && fits;

  assign lo_idx = idx - sweep_val;
  assign hi_sum = {1'b0, idx} + {1'b0, sweep_val};
  assign lo_ok  = (idx >= sweep_val);
  assign hi_ok  = (int'(hi_sum) < sswc_pkg::TABLE_SIZE);
  assign lo_one = ({1'b0, idx} == (sswc_pkg::IDX_W + 1)'(sswc_pkg::MAX_SUM) + {1'b0, sweep_val});
  assign hi_one = (hi_sum == (sswc_pkg::IDX_W + 1)'(sswc_pkg::MAX_SUM));

  assign ram_raddr_a = (state == sswc_pkg::ST_SWEEP) ? {bank_select, lo_idx}
                                                      : {bank_select, t_idx};
  assign ram_raddr_b = {bank_select, hi_sum[sswc_pkg::IDX_W-1:0]};

  // On the first item of a list the source is a single count at total zero,
  // so the old bank contents are not used.
  assign lo_term = delta_src ? sswc_pkg::count_t'(p_lo_one) : (p_lo ? ram_rdata_a : '0);
  assign hi_term = delta_src ? sswc_pkg::count_t'(p_hi_one) : (p_hi ? ram_rdata_b : '0);

  assign ram_we    = p_valid;
  assign ram_waddr = {~bank_select, p_idx};
  assign ram_wdata = sswc_pkg::sat_add(lo_term, hi_term);

  sswc_ram #(
    .WIDTH (sswc_pkg::COUNT_BITS),
    .DEPTH (sswc_pkg::RAM_DEPTH)
  ) u_counts (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  always_comb begin
    state_next = state;
    case (state)
      sswc_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_next = start_sweep ? sswc_pkg::ST_SWEEP : sswc_pkg::ST_FINISH;
        end
      end
      sswc_pkg::ST_SWEEP: begin
        if (int'(idx) == sswc_pkg::TABLE_SIZE - 1) begin
          state_next = sswc_pkg::ST_DRAIN;
        end
      end
      sswc_pkg::ST_DRAIN: begin
        state_next = sswc_pkg::ST_FINISH;
      end
      sswc_pkg::ST_FINISH: begin
        state_next = item_last ? sswc_pkg::ST_RESULT : sswc_pkg::ST_IDLE;
      end
      sswc_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = sswc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sswc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sswc_pkg::ST_IDLE;
      running_total <= '0;
      bank_select   <= 1'b0;
      overflow_seen <= 1'b0;
      delta_src     <= 1'b0;
      p_valid       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state    <= state_next;
      p_valid  <= (state == sswc_pkg::ST_SWEEP);
      p_idx    <= idx;
      p_lo     <= lo_ok;
      p_hi     <= hi_ok;
      p_lo_one <= lo_one;
      p_hi_one <= hi_one;

      // In ST_RESULT the result register loads when it is free; otherwise a taken result clears it.
      if (state == sswc_pkg::ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= (!overflow_seen && t_ok) ? sswc_pkg::ways_sat(ram_rdata_a) : '0;
        m_tuser  <= overflow_seen;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        sswc_pkg::ST_IDLE: begin
          if (s_fire) begin
            sweep_val     <= sswc_pkg::IDX_W'(value);
            item_last     <= s_tlast;
            t_ok          <= (int'(target) >= -sswc_pkg::MAX_SUM) &&
                             (int'(target) <= sswc_pkg::MAX_SUM);
            t_idx         <= sswc_pkg::IDX_W'(int'(target) + sswc_pkg::MAX_SUM);
            idx           <= '0;
            delta_src     <= s_tuser;
            overflow_seen <= ovf_base || !fits;
            running_total <= start_sweep
                             ? sswc_pkg::TOTAL_W'(int'(total_base) + int'(value))
                             : total_base;
          end
        end
        sswc_pkg::ST_SWEEP: begin
          idx <= idx + 1'b1;
        end
        sswc_pkg::ST_DRAIN: begin
          bank_select <= ~bank_select;
        end
        default: begin
        end
      endcase
    end
  end

  `SSWC_ASSERT_ALWAYS(a_total_bound, int'(running_total) <= sswc_pkg::MAX_SUM, "running total above limit")
  `SSWC_ASSERT_ALWAYS(a_write_in_sweep, !ram_we || state == sswc_pkg::ST_SWEEP || state == sswc_pkg::ST_DRAIN, "table write outside a sweep")
  `SSWC_ASSERT_NEXT(a_bank_flip, state == sswc_pkg::ST_DRAIN, bank_select != $past(bank_select), "bank not swapped after sweep")
  `SSWC_ASSERT_NEXT(a_ovf_no_sweep, s_fire && !s_tuser && overflow_seen, state == sswc_pkg::ST_FINISH, "sweep started after overflow")
  `SSWC_ASSERT_NEXT(a_ovf_zero, state == sswc_pkg::ST_RESULT && out_free && overflow_seen, m_tvalid && m_tuser && m_tdata == '0, "overflowed list gave nonzero ways")

endmodule

`default_nettype wire
